// ----- rtl/kpi_pkg.sv -----
// Shared constants, command and status codes, and divider request type.
package kpi_pkg;

    localparam int MAX_TRACKS = 8;
    localparam int MAX_KEYS   = 32;
    localparam int TRACK_W    = $clog2(MAX_TRACKS);
    localparam int KEY_W      = $clog2(MAX_KEYS);
    localparam int CNT_W      = KEY_W + 1;
    localparam int TIU_W      = TRACK_W + 1;
    localparam int ADDR_W     = TRACK_W + KEY_W;
    localparam int DEPTH      = MAX_TRACKS * MAX_KEYS;
    localparam int POSE_N     = 7;
    localparam int VAL_W      = 32;
    localparam int FOV_W      = 24;
    localparam int POSE_W     = POSE_N * VAL_W;
    localparam int STEP_W     = 6;
    localparam int FRAC_W     = 16;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_NOP    = 2'd3;

    localparam logic [1:0] ST_POSE    = 2'd0;
    localparam logic [1:0] ST_NO_KEYS = 2'd1;
    localparam logic [1:0] ST_STORED  = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic [2:0] LOOP_ENABLE_ADDR = 3'd0;

    localparam logic [STEP_W-1:0] MOD_STEPS    = STEP_W'(VAL_W);
    localparam logic [STEP_W-1:0] WEIGHT_STEPS = STEP_W'(FRAC_W);
    localparam logic [FRAC_W:0]   WEIGHT_ONE   = {1'b1, {FRAC_W{1'b0}}};

    typedef struct packed {
        logic              start;
        logic [VAL_W-1:0]  init_rem;
        logic [VAL_W-1:0]  dividend;
        logic [VAL_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } div_req_t;

endpackage

// ----- rtl/kpi_divider.sv -----
// Restoring divider, one quotient bit per cycle.
module kpi_divider
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  kpi_pkg::div_req_t      req,
    output logic                   done,
    output logic [kpi_pkg::VAL_W-1:0] quotient,
    output logic [kpi_pkg::VAL_W-1:0] remainder
);

    logic [kpi_pkg::VAL_W:0]        rem_reg;
    logic [kpi_pkg::VAL_W-1:0]      dq_reg;
    logic [kpi_pkg::VAL_W-1:0]      q_reg;
    logic [kpi_pkg::VAL_W-1:0]      dvs_reg;
    logic [kpi_pkg::STEP_W-1:0]     cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [kpi_pkg::VAL_W:0]        shifted;
    logic                           ge;
    logic [kpi_pkg::VAL_W:0]        rem_next;

    always_comb
    begin
        shifted  = {rem_reg[kpi_pkg::VAL_W-1:0], dq_reg[kpi_pkg::VAL_W-1]};
        ge       = shifted >= {1'b0, dvs_reg};
        rem_next = ge ? shifted - {1'b0, dvs_reg} : shifted;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= req.steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == kpi_pkg::STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= {1'b0, req.init_rem};
            dq_reg  <= req.dividend;
            dvs_reg <= req.divisor;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dq_reg  <= {dq_reg[kpi_pkg::VAL_W-2:0], 1'b0};
            q_reg   <= {q_reg[kpi_pkg::VAL_W-2:0], ge};
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = rem_reg[kpi_pkg::VAL_W-1:0];

endmodule

// ----- rtl/keyframe_pose_interpolator_core.sv -----
// Keyframe pose interpolator top level: key memories, query sequencer, output register.
// For clear and append, out_valid rises once S_DONE finds the output register free; a query first runs
// the last-key read, a time wrap when looping, the serial key search, the reads of both keys, a
// weight division when needed, the 7 serial multiply-adds and S_DONE; wrap and weight use the
// bit-serial divider. One item is in work at a time; the next is accepted once the result is
// loaded into the output register. Reset clears key counts, tracks in use, loop_enable and
// handshake state; key memories are not.
module keyframe_pose_interpolator_core
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic [2:0]         track,
    input  logic [31:0]        time_value,
    input  logic signed [31:0] in_x,
    input  logic signed [31:0] in_y,
    input  logic signed [31:0] in_z,
    input  logic signed [31:0] in_rot_x,
    input  logic signed [31:0] in_rot_y,
    input  logic signed [31:0] in_rot_z,
    input  logic [23:0]        in_fov,
    // output channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic signed [31:0] out_rot_x,
    output logic signed [31:0] out_rot_y,
    output logic signed [31:0] out_rot_z,
    output logic [23:0]        out_fov
);

    typedef enum logic [3:0] {
        S_IDLE, S_LAST, S_LAST_USE, S_MOD, S_SRCH_RD, S_SRCH_CMP,
        S_KA_RD, S_KB_RD, S_KB_USE, S_WDIV, S_MUL, S_ADD, S_DONE
    } state_t;

    localparam int VW = kpi_pkg::VAL_W;

    // ---------------- configuration register ----------------
    logic loop_reg;
    logic cfg_wr;

    // one register at addresses 0 to 3 (paddr[2] low); addresses 4 to 7 read as zero and ignore writes
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, loop_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            loop_reg <= 1'b0;
        else if (cfg_wr)
            loop_reg <= pwdata[0];
    end

    // ---------------- state ----------------
    state_t                                state_reg;
    logic [kpi_pkg::CNT_W-1:0]             cnt_reg [kpi_pkg::MAX_TRACKS];
    logic [kpi_pkg::TIU_W-1:0]             tiu_reg;
    logic [kpi_pkg::TRACK_W-1:0]           ti_reg;
    logic [kpi_pkg::CNT_W-1:0]             n_reg;
    logic [VW-1:0]                         t_reg;
    logic [VW-1:0]                         last_reg;
    logic [kpi_pkg::KEY_W-1:0]             idx_reg;
    logic [kpi_pkg::KEY_W-1:0]             i0_reg;
    logic [kpi_pkg::KEY_W-1:0]             i1_reg;
    logic [VW-1:0]                         ta_reg;
    logic [kpi_pkg::POSE_W-1:0]            a_reg;
    logic [kpi_pkg::POSE_W-1:0]            b_reg;
    logic [kpi_pkg::FRAC_W:0]              f_reg;
    logic [2:0]                            j_reg;
    logic signed [VW+kpi_pkg::FRAC_W+2:0]  prod_reg;
    logic [VW-1:0]                         res_reg [kpi_pkg::POSE_N];
    logic [1:0]                            stat_reg;
    logic                                  out_valid_reg;
    logic [1:0]                            ostat_reg;
    logic [VW-1:0]                         opose_reg [kpi_pkg::POSE_N];

    // ---------------- key memories ----------------
    logic [VW-1:0]                 time_mem [kpi_pkg::DEPTH];
    logic [kpi_pkg::POSE_W-1:0]    pose_mem [kpi_pkg::DEPTH];
    logic [VW-1:0]                 rd_time_reg;
    logic [kpi_pkg::POSE_W-1:0]    rd_pose_reg;
    logic [kpi_pkg::ADDR_W-1:0]    rd_addr;
    logic [kpi_pkg::ADDR_W-1:0]    wr_addr;
    logic                          wr_en;
    logic                          accept;
    logic [kpi_pkg::CNT_W-1:0]     trk_cnt;
    logic                          trk_full;

    assign accept   = in_valid && in_ready;
    assign trk_cnt  = cnt_reg[track];
    assign trk_full = trk_cnt >= kpi_pkg::CNT_W'(kpi_pkg::MAX_KEYS);
    assign wr_en    = accept && (command == kpi_pkg::CMD_APPEND) && !trk_full;
    assign wr_addr  = {track, trk_cnt[kpi_pkg::KEY_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            time_mem[wr_addr] <= time_value;
            pose_mem[wr_addr] <= {{(VW-kpi_pkg::FOV_W){1'b0}}, in_fov, in_rot_z, in_rot_y,
                                  in_rot_x, in_z, in_y, in_x};
        end
        rd_time_reg <= time_mem[rd_addr];
        rd_pose_reg <= pose_mem[rd_addr];
    end

    // ---------------- datapath helpers ----------------
    logic [kpi_pkg::CNT_W-1:0]     n_m1_w;
    logic [kpi_pkg::KEY_W-1:0]     n_m1;
    logic                          srch_hit;
    logic                          srch_end;
    logic                          early;
    logic                          hold_last;
    logic [kpi_pkg::KEY_W-1:0]     i0_c;
    logic [kpi_pkg::KEY_W-1:0]     i1_c;
    logic                          key_hold;
    logic [VW-1:0]                 w_diff;
    logic [VW-1:0]                 w_span;
    logic                          w_sat;
    logic                          mod_go;
    logic signed [VW:0]            a_f;
    logic signed [VW:0]            b_f;
    logic signed [VW:0]            dd;
    logic signed [VW+kpi_pkg::FRAC_W+2:0] shifted;
    logic [kpi_pkg::TRACK_W-1:0]   q_ti;
    kpi_pkg::div_req_t             div_req;
    logic                          div_done;
    logic [VW-1:0]                 div_q;
    logic [VW-1:0]                 div_r;

    always_comb
    begin
        n_m1_w    = n_reg - 1'b1;
        n_m1      = n_m1_w[kpi_pkg::KEY_W-1:0];
        srch_hit  = rd_time_reg > t_reg;
        srch_end  = srch_hit || (idx_reg == n_m1);
        early     = srch_hit && (idx_reg == '0);
        i0_c      = srch_hit ? (early ? '0 : idx_reg - 1'b1) : n_m1;
        i1_c      = (srch_hit && !early) ? idx_reg : '0;
        hold_last = !early && (t_reg >= last_reg) && !loop_reg;
        if (hold_last)
        begin
            i0_c = n_m1;
            i1_c = n_m1;
        end
        key_hold  = (i0_reg == i1_reg) || (rd_time_reg <= ta_reg);
        w_diff    = (t_reg >= ta_reg) ? t_reg - ta_reg : '0;
        w_span    = rd_time_reg - ta_reg;
        w_sat     = w_diff >= w_span;
        mod_go    = loop_reg && (rd_time_reg != '0);
        a_f       = {a_reg[VW*j_reg + VW-1], a_reg[VW*j_reg +: VW]};
        b_f       = {b_reg[VW*j_reg + VW-1], b_reg[VW*j_reg +: VW]};
        dd        = b_f - a_f;
        shifted   = prod_reg >>> kpi_pkg::FRAC_W;
        q_ti      = ({1'b0, track} < tiu_reg) ? track : '0;
    end

    // memory read address follows the sequencer state
    always_comb
    begin
        unique case (state_reg)
            S_LAST:    rd_addr = {ti_reg, n_m1};
            S_SRCH_RD: rd_addr = {ti_reg, idx_reg};
            S_KA_RD:   rd_addr = {ti_reg, i0_reg};
            S_KB_RD:   rd_addr = {ti_reg, i1_reg};
            default:   rd_addr = '0;
        endcase
    end

    // divider requests: time wrap, then the interpolation weight
    always_comb
    begin
        div_req = '0;
        if (state_reg == S_LAST_USE && mod_go)
        begin
            div_req.start    = 1'b1;
            div_req.init_rem = '0;
            div_req.dividend = t_reg;
            div_req.divisor  = rd_time_reg;
            div_req.steps    = kpi_pkg::MOD_STEPS;
        end
        else if (state_reg == S_KB_USE && !key_hold && !w_sat)
        begin
            div_req.start    = 1'b1;
            div_req.init_rem = w_diff;
            div_req.dividend = '0;
            div_req.divisor  = w_span;
            div_req.steps    = kpi_pkg::WEIGHT_STEPS;
        end
    end

    kpi_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tiu_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < kpi_pkg::MAX_TRACKS; k++)
                cnt_reg[k] <= '0;
        end
        else
        begin
            // drop the taken beat unless a new result is loaded in the same cycle
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        for (int k = 0; k < kpi_pkg::POSE_N; k++)
                            res_reg[k] <= '0;
                        unique case (command)
                            kpi_pkg::CMD_CLEAR:
                            begin
                                for (int k = 0; k < kpi_pkg::MAX_TRACKS; k++)
                                    cnt_reg[k] <= '0;
                                tiu_reg   <= '0;
                                stat_reg  <= kpi_pkg::ST_NO_KEYS;
                                state_reg <= S_DONE;
                            end
                            kpi_pkg::CMD_APPEND:
                            begin
                                if (trk_full)
                                    stat_reg <= kpi_pkg::ST_FULL;
                                else
                                begin
                                    cnt_reg[track] <= trk_cnt + 1'b1;
                                    if ({1'b0, track} >= tiu_reg)
                                        tiu_reg <= {1'b0, track} + 1'b1;
                                    stat_reg <= kpi_pkg::ST_STORED;
                                end
                                state_reg <= S_DONE;
                            end
                            kpi_pkg::CMD_QUERY:
                            begin
                                ti_reg <= q_ti;
                                n_reg  <= cnt_reg[q_ti];
                                t_reg  <= time_value;
                                if (cnt_reg[q_ti] == '0)
                                begin
                                    stat_reg  <= kpi_pkg::ST_NO_KEYS;
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    stat_reg  <= kpi_pkg::ST_POSE;
                                    state_reg <= S_LAST;
                                end
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_LAST:
                    state_reg <= S_LAST_USE;
                S_LAST_USE:
                begin
                    last_reg <= rd_time_reg;
                    idx_reg  <= '0;
                    state_reg <= mod_go ? S_MOD : S_SRCH_RD;
                end
                S_MOD:
                begin
                    if (div_done)
                    begin
                        t_reg     <= div_r;
                        state_reg <= S_SRCH_RD;
                    end
                end
                S_SRCH_RD:
                    state_reg <= S_SRCH_CMP;
                S_SRCH_CMP:
                begin
                    if (srch_end)
                    begin
                        i0_reg    <= i0_c;
                        i1_reg    <= i1_c;
                        state_reg <= S_KA_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_SRCH_RD;
                    end
                end
                S_KA_RD:
                    state_reg <= S_KB_RD;
                S_KB_RD:
                begin
                    ta_reg    <= rd_time_reg;
                    a_reg     <= rd_pose_reg;
                    state_reg <= S_KB_USE;
                end
                S_KB_USE:
                begin
                    b_reg <= rd_pose_reg;
                    j_reg <= '0;
                    if (key_hold)
                    begin
                        f_reg     <= '0;
                        state_reg <= S_MUL;
                    end
                    else if (w_sat)
                    begin
                        f_reg     <= kpi_pkg::WEIGHT_ONE;
                        state_reg <= S_MUL;
                    end
                    else
                        state_reg <= S_WDIV;
                end
                S_WDIV:
                begin
                    if (div_done)
                    begin
                        f_reg     <= {1'b0, div_q[kpi_pkg::FRAC_W-1:0]};
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= dd * $signed({1'b0, f_reg});
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    res_reg[j_reg] <= a_f[VW-1:0] + shifted[VW-1:0];
                    if (j_reg == 3'(kpi_pkg::POSE_N - 1))
                        state_reg <= S_DONE;
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_MUL;
                    end
                end
                S_DONE:
                begin
                    // load the result once the output register is free
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        ostat_reg     <= stat_reg;
                        for (int k = 0; k < kpi_pkg::POSE_N; k++)
                            opose_reg[k] <= res_reg[k];
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // ---------------- ports ----------------
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = ostat_reg;
    assign out_x     = opose_reg[0];
    assign out_y     = opose_reg[1];
    assign out_z     = opose_reg[2];
    assign out_rot_x = opose_reg[3];
    assign out_rot_y = opose_reg[4];
    assign out_rot_z = opose_reg[5];
    assign out_fov   = opose_reg[6][kpi_pkg::FOV_W-1:0];

`ifndef SYNTH
    // a command that produces a result keeps the input closed for the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (command != kpi_pkg::CMD_NOP) |=> !in_ready)
        else $error("input reopened right after accepted beat");

    // a non-pose result carries an all-zero pose (checked on out_x and out_fov)
    a_zero_pose: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != kpi_pkg::ST_POSE) |-> (out_x == '0) && (out_fov == '0))
        else $error("non-pose result carries pose data");

    // a query only reaches the key memory with a non-empty track
    a_query_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LAST) |-> (n_reg != '0))
        else $error("query walked an empty track");

    // result waits in the output register until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("pending result dropped or changed");
`endif

endmodule
